// ===== rtl/core/irr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP request reassembler package
// Shared widths, protocol constants, result codes and control bundles.
// ----------------------------------------------------------------------------
package irr_pkg;

  localparam int unsigned ID_W          = 29;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MSG_LEN_W     = 12;
  localparam int unsigned SEQ_W         = 4;
  localparam int unsigned FRAME_BYTES   = 8;
  localparam int unsigned MSG_BYTES_DEF = 64;
  localparam int unsigned MAX_CHUNKS    = 8;

  // protocol control information, high nibble of the first byte
  localparam logic [3:0] PCI_SF  = 4'h0;
  localparam logic [3:0] PCI_FF  = 4'h1;
  localparam logic [3:0] PCI_CF  = 4'h2;
  localparam logic [3:0] PCI_FCT = 4'h3;

  localparam logic [7:0]           FC_BYTE       = 8'h30;
  localparam logic [LEN_W-1:0]     CMD_LEN_MAX   = 4'd7;
  localparam logic [LEN_W-1:0]     FRAME_LEN_MAX = 4'd8;
  localparam logic [LEN_W-1:0]     SF_LEN_MAX    = 4'd7;
  localparam logic [LEN_W-1:0]     FF_PCI_BYTES  = 4'd2;
  localparam logic [MSG_LEN_W-1:0] FF_LEN_MIN    = 12'd8;
  localparam logic [2:0]           CF_PAY_MAX    = 3'd7;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CHUNK = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SEQUENCE = 3'd1,
    ERR_FLOW     = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_BUSY     = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ERROR   = 3'd1,
    OP_SEQ_ERR = 3'd2,
    OP_START   = 3'd3,
    OP_FREE    = 3'd4,
    OP_SF      = 3'd5,
    OP_FF      = 3'd6,
    OP_CF      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    OUT_SEND  = 3'd0,
    OUT_FREE  = 3'd1,
    OUT_FC    = 3'd2,
    OUT_ERR   = 3'd3,
    OUT_OVF   = 3'd4,
    OUT_CHUNK = 3'd5
  } out_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     dec_latch;
    logic     wr_clr;
    logic     wr_step;
    logic     wr_en;
    logic     commit;
    logic     start_load;
    logic     busy_clr;
    logic     chunk_clr;
    logic     chunk_step;
    logic     rd_en;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic wr_none;
    logic wr_last;
    logic cf_done;
    logic ovf;
    logic chunk_last;
    logic out_free;
    logic in_valid;
  } sts_t;

endpackage

// ===== rtl/core/irr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP request reassembler input channel
// Valid/ready channel carrying one received frame or one start command.
// ----------------------------------------------------------------------------
interface irr_in_if import irr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   can_id;
  logic [ID_W-1:0]   reply_id;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] byte0;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [BYTE_W-1:0] byte3;
  logic [BYTE_W-1:0] byte4;
  logic [BYTE_W-1:0] byte5;
  logic [BYTE_W-1:0] byte6;
  logic [BYTE_W-1:0] byte7;

  modport source (
    output valid, action, can_id, reply_id, frame_length,
    output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    input  ready
  );

  modport sink (
    input  valid, action, can_id, reply_id, frame_length,
    input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    output ready
  );

endinterface

// ===== rtl/core/irr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP request reassembler output channel
// Valid/ready channel carrying frames to send, free frames, chunks, errors.
// ----------------------------------------------------------------------------
interface irr_out_if import irr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ID_W-1:0]   out_id;
  logic [LEN_W-1:0]  count;
  logic [BYTE_W-1:0] out0;
  logic [BYTE_W-1:0] out1;
  logic [BYTE_W-1:0] out2;
  logic [BYTE_W-1:0] out3;
  logic [BYTE_W-1:0] out4;
  logic [BYTE_W-1:0] out5;
  logic [BYTE_W-1:0] out6;
  logic [BYTE_W-1:0] out7;
  logic              last;

  modport source (
    output valid, kind, out_id, count, last,
    output out0, out1, out2, out3, out4, out5, out6, out7,
    input  ready
  );

  modport sink (
    input  valid, kind, out_id, count, last,
    input  out0, out1, out2, out3, out4, out5, out6, out7,
    output ready
  );

endinterface

// ===== rtl/core/irr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP request reassembler controller
// One-hot sequencer: decode, byte writes, state commit, chunk reads, result emission.
// ----------------------------------------------------------------------------
module irr_ctrl import irr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_WRITE    = 9'b000001000,
    S_COMMIT   = 9'b000010000,
    S_EMIT1    = 9'b000100000,
    S_EMIT2    = 9'b001000000,
    S_READ     = 9'b010000000,
    S_CHUNK    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.out_sel = OUT_ERR;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.dec_latch = 1'b1;
        cmd_o.wr_clr    = 1'b1;
        state_d         = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_NONE: state_d = S_IDLE;
          OP_SF, OP_FF, OP_CF: state_d = sts_i.wr_none ? S_COMMIT : S_WRITE;
          default: state_d = S_EMIT1;
        endcase
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.wr_last) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.wr_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit    = 1'b1;
        cmd_o.chunk_clr = 1'b1;
        case (sts_i.op)
          OP_FF:   state_d = S_EMIT1;
          OP_CF:   state_d = sts_i.cf_done ? S_READ : S_IDLE;
          default: state_d = S_READ;
        endcase
      end
      S_EMIT1: begin
        case (sts_i.op)
          OP_START: cmd_o.out_sel = OUT_SEND;
          OP_FREE:  cmd_o.out_sel = OUT_FREE;
          OP_FF:    cmd_o.out_sel = OUT_FC;
          default:  cmd_o.out_sel = OUT_ERR;
        endcase
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.start_load = (sts_i.op == OP_START);
          // a sequence error ends the transaction
          cmd_o.busy_clr   = (sts_i.op == OP_SEQ_ERR);
          state_d = (sts_i.op == OP_FF && sts_i.ovf) ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        cmd_o.out_sel = OUT_OVF;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHUNK;
      end
      S_CHUNK: begin
        cmd_o.out_sel = OUT_CHUNK;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.chunk_last) begin
            cmd_o.busy_clr = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.chunk_step = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/irr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP request reassembler datapath
// Input capture, frame decode, transaction state, message store, result register.
// ----------------------------------------------------------------------------
module irr_dp import irr_pkg::*; #(
  parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  irr_in_if.sink    in_i,
  irr_out_if.source out_o
);

  localparam int unsigned ROWS  = (MSG_BYTES + 7) / 8;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CAP   = (MSG_BYTES < MAX_CHUNKS * 8) ? MSG_BYTES : MAX_CHUNKS * 8;
  localparam logic [MSG_LEN_W-1:0] MSG_LIMIT = MSG_LEN_W'(MSG_BYTES);
  localparam logic [MSG_LEN_W-1:0] CAP_LEN   = MSG_LEN_W'(CAP);

  typedef struct packed {
    op_e                  op;
    err_e                 code;
    logic [2:0]           wr_total;
    logic [1:0]           src;
    logic [MSG_LEN_W-1:0] base;
    logic [MSG_LEN_W-1:0] new_len;
    logic [SEQ_W-1:0]     seq;
    logic                 cf_done;
    logic                 ovf;
  } dec_t;

  // captured item
  logic                 act_q;
  logic [ID_W-1:0]      id_q;
  logic [ID_W-1:0]      rid_q;
  logic [LEN_W-1:0]     len_q;
  logic [BYTE_W-1:0]    d_q [FRAME_BYTES];

  // transaction state
  logic                 busy_q;
  logic [ID_W-1:0]      send_id_q;
  logic [ID_W-1:0]      expect_id_q;
  logic [MSG_LEN_W-1:0] msg_len_q;
  logic [MSG_LEN_W-1:0] fill_q;
  logic [SEQ_W-1:0]     last_seq_q;

  dec_t                 dec, dec_q;
  logic [2:0]           wr_cnt_q;
  logic [2:0]           chunk_q;

  logic [BYTE_W-1:0]    mem_q [ROWS][FRAME_BYTES];
  logic [BYTE_W-1:0]    rd_q  [FRAME_BYTES];

  logic                 in_fire;
  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= in_i.action;
      id_q   <= in_i.can_id;
      rid_q  <= in_i.reply_id;
      len_q  <= in_i.frame_length;
      d_q[0] <= in_i.byte0;
      d_q[1] <= in_i.byte1;
      d_q[2] <= in_i.byte2;
      d_q[3] <= in_i.byte3;
      d_q[4] <= in_i.byte4;
      d_q[5] <= in_i.byte5;
      d_q[6] <= in_i.byte6;
      d_q[7] <= in_i.byte7;
    end
  end

  // --------------------------------------------------------------------------
  // Decode
  // --------------------------------------------------------------------------
  logic [3:0]           pci_hi, pci_lo;
  logic [MSG_LEN_W-1:0] ff_len, cf_rem;
  logic [2:0]           cf_pay;
  logic [LEN_W-1:0]     cf_need;
  logic [LEN_W:0]       sf_need;

  assign pci_hi  = d_q[0][7:4];
  assign pci_lo  = d_q[0][3:0];
  assign ff_len  = {pci_lo, d_q[1]};
  assign cf_rem  = msg_len_q - fill_q;
  assign cf_pay  = (cf_rem > MSG_LEN_W'(CF_PAY_MAX)) ? CF_PAY_MAX : cf_rem[2:0];
  assign cf_need = LEN_W'(cf_pay) + LEN_W'(1);
  assign sf_need = (LEN_W+1)'(pci_lo) + (LEN_W+1)'(1);

  always_comb begin
    dec          = '0;
    dec.op       = OP_NONE;
    dec.code     = ERR_NONE;
    dec.seq      = pci_lo;
    dec.cf_done  = ((fill_q + MSG_LEN_W'(cf_pay)) == msg_len_q);
    dec.ovf      = (ff_len > MSG_LIMIT);
    if (act_q) begin
      if (busy_q) begin
        dec.op   = OP_ERROR;
        dec.code = ERR_BUSY;
      end else if (len_q > CMD_LEN_MAX) begin
        dec.op   = OP_ERROR;
        dec.code = ERR_LENGTH;
      end else begin
        dec.op = OP_START;
      end
    end else if (len_q > FRAME_LEN_MAX) begin
      dec.op   = OP_ERROR;
      dec.code = ERR_LENGTH;
    end else if (!busy_q) begin
      dec.op = OP_FREE;
    end else if (id_q == expect_id_q) begin
      case (pci_hi)
        PCI_SF: begin
          if (pci_lo == '0 || pci_lo > SF_LEN_MAX || sf_need > (LEN_W+1)'(len_q)) begin
            dec.op   = OP_ERROR;
            dec.code = ERR_LENGTH;
          end else begin
            dec.op       = OP_SF;
            dec.wr_total = pci_lo[2:0];
            dec.src      = 2'd1;
            dec.new_len  = MSG_LEN_W'(pci_lo);
          end
        end
        PCI_FF: begin
          if (len_q < FF_PCI_BYTES || ff_len < FF_LEN_MIN) begin
            dec.op   = OP_ERROR;
            dec.code = ERR_LENGTH;
          end else begin
            dec.op       = OP_FF;
            dec.wr_total = 3'(len_q - FF_PCI_BYTES);
            dec.src      = 2'd2;
            dec.new_len  = ff_len;
          end
        end
        PCI_CF: begin
          // ignore unless a first frame has opened a message that is not yet complete
          if (msg_len_q != '0 && fill_q < msg_len_q) begin
            if (pci_lo != last_seq_q + SEQ_W'(1)) begin
              dec.op   = OP_SEQ_ERR;
              dec.code = ERR_SEQUENCE;
            end else if (len_q < cf_need) begin
              dec.op   = OP_ERROR;
              dec.code = ERR_LENGTH;
            end else begin
              dec.op       = OP_CF;
              dec.wr_total = cf_pay;
              dec.src      = 2'd1;
              dec.base     = fill_q;
            end
          end
        end
        PCI_FCT: begin
          dec.op   = OP_ERROR;
          dec.code = ERR_FLOW;
        end
        default: dec.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_latch) begin
      dec_q <= dec;
    end
  end

  // --------------------------------------------------------------------------
  // Transaction state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      send_id_q   <= '0;
      expect_id_q <= '0;
      msg_len_q   <= '0;
      fill_q      <= '0;
      last_seq_q  <= '0;
    end else begin
      if (cmd_i.start_load) begin
        busy_q      <= 1'b1;
        send_id_q   <= id_q;
        expect_id_q <= rid_q;
        msg_len_q   <= '0;
        fill_q      <= '0;
        last_seq_q  <= '0;
      end
      if (cmd_i.commit) begin
        case (dec_q.op)
          OP_SF: begin
            msg_len_q <= dec_q.new_len;
            fill_q    <= dec_q.new_len;
          end
          OP_FF: begin
            msg_len_q  <= dec_q.new_len;
            fill_q     <= MSG_LEN_W'(dec_q.wr_total);
            last_seq_q <= '0;
          end
          OP_CF: begin
            fill_q     <= fill_q + MSG_LEN_W'(dec_q.wr_total);
            last_seq_q <= dec_q.seq;
          end
          default: ;
        endcase
      end
      if (cmd_i.busy_clr) begin
        busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Message store: byte writes, one 8-byte row read per chunk
  // --------------------------------------------------------------------------
  logic [MSG_LEN_W-1:0] wr_addr;
  logic [2:0]           wr_src;
  logic [ROW_W-1:0]     wr_row, rd_row;

  assign wr_addr = dec_q.base + MSG_LEN_W'(wr_cnt_q);
  assign wr_src  = 3'(dec_q.src) + wr_cnt_q;
  assign wr_row  = ROW_W'(wr_addr[MSG_LEN_W-1:3]);
  assign rd_row  = ROW_W'(chunk_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      chunk_q  <= '0;
    end else begin
      if (cmd_i.wr_clr) begin
        wr_cnt_q <= '0;
      end else if (cmd_i.wr_step) begin
        wr_cnt_q <= wr_cnt_q + 3'd1;
      end
      if (cmd_i.chunk_clr) begin
        chunk_q <= '0;
      end else if (cmd_i.chunk_step) begin
        chunk_q <= chunk_q + 3'd1;
      end
    end
  end

  // drop bytes past the end of the store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_addr < MSG_LIMIT) begin
      mem_q[wr_row][wr_addr[2:0]] <= d_q[wr_src];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_row];
    end
  end

  logic [6:0]       total_len, chunk_rem;
  logic [LEN_W-1:0] chunk_cnt;
  logic             chunk_last;

  assign total_len  = (msg_len_q > CAP_LEN) ? 7'(CAP) : msg_len_q[6:0];
  assign chunk_rem  = total_len - {1'b0, chunk_q, 3'b000};
  assign chunk_last = (chunk_rem <= 7'd8);
  assign chunk_cnt  = chunk_last ? chunk_rem[LEN_W-1:0] : LEN_W'(FRAME_BYTES);

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_valid_q;
  kind_e             out_kind_q, okind;
  logic [ID_W-1:0]   out_id_q, oid;
  logic [LEN_W-1:0]  out_cnt_q, ocnt;
  logic              out_last_q, olast;
  logic [BYTE_W-1:0] out_b_q [FRAME_BYTES];
  logic [BYTE_W-1:0] ob      [FRAME_BYTES];
  logic              out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    okind = KIND_ERROR;
    oid   = '0;
    ocnt  = '0;
    olast = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      ob[i] = '0;
    end
    case (cmd_i.out_sel)
      OUT_SEND: begin
        okind = KIND_SEND;
        oid   = id_q;
        ocnt  = LEN_W'(FRAME_BYTES);
        ob[0] = BYTE_W'(len_q);
        for (int i = 1; i < FRAME_BYTES; i++) begin
          ob[i] = (LEN_W'(i - 1) < len_q) ? d_q[i-1] : '0;
        end
      end
      OUT_FREE: begin
        okind = KIND_FREE;
        oid   = id_q;
        ocnt  = len_q;
        for (int i = 0; i < FRAME_BYTES; i++) begin
          ob[i] = (LEN_W'(i) < len_q) ? d_q[i] : '0;
        end
      end
      OUT_FC: begin
        okind = KIND_SEND;
        oid   = send_id_q;
        ocnt  = LEN_W'(FRAME_BYTES);
        ob[0] = FC_BYTE;
      end
      OUT_ERR: begin
        ob[0] = BYTE_W'(dec_q.code);
      end
      OUT_OVF: begin
        ob[0] = BYTE_W'(ERR_OVERFLOW);
      end
      OUT_CHUNK: begin
        okind = KIND_CHUNK;
        ocnt  = chunk_cnt;
        olast = chunk_last;
        for (int i = 0; i < FRAME_BYTES; i++) begin
          ob[i] = (LEN_W'(i) < chunk_cnt) ? rd_q[i] : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= okind;
      out_id_q   <= oid;
      out_cnt_q  <= ocnt;
      out_last_q <= olast;
      out_b_q    <= ob;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.out_id = out_id_q;
  assign out_o.count  = out_cnt_q;
  assign out_o.last   = out_last_q;
  assign out_o.out0   = out_b_q[0];
  assign out_o.out1   = out_b_q[1];
  assign out_o.out2   = out_b_q[2];
  assign out_o.out3   = out_b_q[3];
  assign out_o.out4   = out_b_q[4];
  assign out_o.out5   = out_b_q[5];
  assign out_o.out6   = out_b_q[6];
  assign out_o.out7   = out_b_q[7];

  assign sts_o.op         = dec_q.op;
  assign sts_o.wr_none    = (dec_q.wr_total == '0);
  assign sts_o.wr_last    = (wr_cnt_q == dec_q.wr_total - 3'd1);
  assign sts_o.cf_done    = dec_q.cf_done;
  assign sts_o.ovf        = dec_q.ovf;
  assign sts_o.chunk_last = chunk_last;
  assign sts_o.out_free   = out_free;
  assign sts_o.in_valid   = in_i.valid;

endmodule

// ===== rtl/core/isotp_request_reassembler_unit.sv =====
`timescale 1ns / 1ps
// Sequence: an accepted item is captured, decoded and dispatched; an error, free frame
//   or send frame is then loaded into the output register, and a flow-control frame
//   follows the payload byte writes and the commit. When a message completes, chunks
//   follow the commit, each a row read and then a load into the output register.
// Items: one at a time, accepted only in the idle state; output stalls hold the controller.
// Reset: controller, counters and transaction state clear; message store is not cleared.
// ----------------------------------------------------------------------------
// ISO-TP request reassembler
// Sends single-frame requests and reassembles reply messages into chunks.
// ----------------------------------------------------------------------------
module isotp_request_reassembler_unit import irr_pkg::*; #(
  parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  irr_in_if.sink    in_i,
  irr_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  irr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  irr_dp #(
    .MSG_BYTES (MSG_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // one input item in progress at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous item still in progress");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before being taken");

  a_last_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.kind == KIND_CHUNK))
    else $error("last flag on a result that is not a chunk");

  a_chunk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_CHUNK) |->
      (out_o.count != '0 && out_o.count <= FRAME_LEN_MAX))
    else $error("chunk byte count out of range");

endmodule
